@@ hw/rtl/lsgs_pkg.sv @@
// Shared types and constants of the laser scan grid sequencer.
// No dependencies.
package lsgs_pkg;
	localparam int unsigned DefMaxSamples = 1024;
	localparam bit DefZigzag = 1'b0;
	localparam logic [7:0] DimLevel = 8'd10;
	localparam logic [16:0] FracOne = 17'h10000;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP = 3'd1,
		OP_STATUS = 3'd2,
		OP_TRI = 3'd3,
		OP_TICK = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_CORNER_A = 3'd0,
		CFG_CORNER_B = 3'd1,
		CFG_CORNER_C = 3'd2,
		CFG_CORNER_D = 3'd3,
		CFG_SAMPLES_U = 3'd4,
		CFG_SAMPLES_V = 3'd5,
		CFG_WARMUP = 3'd6
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic frac_u_start;  // start divider on horizontal fraction
		logic frac_v_start;  // start divider on vertical fraction
		logic blend_start;   // start blend sequence
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frac_done;
		logic blend_done;
	} dp_sts_t;
endpackage

@@ hw/rtl/lsgs_datapath.sv @@
// Datapath: serial fraction divider and multiply-accumulate blend unit.
// Depends on lsgs_pkg.
module lsgs_datapath #(
	parameter int unsigned MAX_SAMPLES = lsgs_pkg::DefMaxSamples,
	parameter int unsigned PW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsgs_pkg::dp_cmd_t     cmd,
	output lsgs_pkg::dp_sts_t     sts,
	input  logic [PW-1:0]         pos,
	input  logic [PW-1:0]         count,
	input  logic [31:0]           corner_a,
	input  logic [31:0]           corner_b,
	input  logic [31:0]           corner_c,
	input  logic [31:0]           corner_d,
	output logic signed [15:0]    res_pan,
	output logic signed [15:0]    res_tilt
);
	import lsgs_pkg::*;

	localparam int unsigned NW = PW + 16;
	localparam int unsigned CW = $clog2(NW + 1);

	// restoring divider: (pos << 16) / (count-1)
	logic [NW-1:0] num_q;
	logic [NW-1:0] rem_q;
	logic [PW-1:0] den_q;
	logic [CW-1:0] dcnt_q;
	logic div_busy_q, div_v_q;
	logic [16:0] fu_q, fv_q;
	logic [NW:0] trial;
	logic [NW-1:0] rem_sh;
	logic [NW-1:0] quo_q;
	logic [16:0] qsat;
	logic [NW-1:0] qfin;

	assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};
	assign trial = {1'b0, rem_sh} - {{(NW+1-PW){1'b0}}, den_q};

	// saturated quotient as it stands on the last divider step
	assign qfin = {quo_q[NW-2:0], ~trial[NW]};
	assign qsat = (qfin > NW'(FracOne)) ? FracOne : qfin[16:0];

	// blend sequencer: six blended values, one per step
	logic [2:0] bstep_q;
	logic blend_busy_q;
	logic signed [17:0] f_s;
	logic signed [16:0] x_s, y_s;
	logic signed [35:0] prod_a, prod_b;
	logic signed [37:0] sum;
	logic signed [16:0] quot;
	logic signed [16:0] abp_q, abt_q, dcp_q, dct_q;
	logic frac_done_q, blend_done_q;

	assign sts.frac_done = frac_done_q;
	assign sts.blend_done = blend_done_q;

	always_comb begin
		f_s = (bstep_q < 3'd4) ? $signed({1'b0, fu_q}) : $signed({1'b0, fv_q});
		case (bstep_q)
			3'd0: begin
				x_s = 17'(signed'(corner_a[15:0]));
				y_s = 17'(signed'(corner_b[15:0]));
			end
			3'd1: begin
				x_s = 17'(signed'(corner_a[31:16]));
				y_s = 17'(signed'(corner_b[31:16]));
			end
			3'd2: begin
				x_s = 17'(signed'(corner_d[15:0]));
				y_s = 17'(signed'(corner_c[15:0]));
			end
			3'd3: begin
				x_s = 17'(signed'(corner_d[31:16]));
				y_s = 17'(signed'(corner_c[31:16]));
			end
			3'd4: begin
				x_s = abp_q;
				y_s = dcp_q;
			end
			default: begin
				x_s = abt_q;
				y_s = dct_q;
			end
		endcase
		prod_a = (18'sd65536 - f_s) * 36'(x_s);
		prod_b = f_s * 36'(y_s);
		sum = 38'(prod_a) + 38'(prod_b);
		// truncate toward zero
		quot = 17'((sum + ((sum < 0) ? 38'sd65535 : 38'sd0)) >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_v_q <= 1'b0;
			dcnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			fu_q <= '0;
			fv_q <= '0;
			blend_busy_q <= 1'b0;
			bstep_q <= '0;
			abp_q <= '0;
			abt_q <= '0;
			dcp_q <= '0;
			dct_q <= '0;
			res_pan <= '0;
			res_tilt <= '0;
			frac_done_q <= 1'b0;
			blend_done_q <= 1'b0;
		end else begin
			frac_done_q <= 1'b0;
			blend_done_q <= 1'b0;
			if (cmd.frac_u_start || cmd.frac_v_start) begin
				div_v_q <= cmd.frac_v_start;
				if (count <= PW'(1)) begin
					if (cmd.frac_v_start) fv_q <= '0;
					else fu_q <= '0;
					frac_done_q <= 1'b1;
				end else begin
					num_q <= {pos, 16'h0};
					den_q <= count - PW'(1);
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= CW'(NW);
					div_busy_q <= 1'b1;
				end
			end else if (div_busy_q) begin
				num_q <= {num_q[NW-2:0], 1'b0};
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == CW'(1)) begin
					div_busy_q <= 1'b0;
					frac_done_q <= 1'b1;
					// capture the saturated quotient
					if (div_v_q) fv_q <= qsat;
					else fu_q <= qsat;
				end
			end
			if (cmd.blend_start) begin
				blend_busy_q <= 1'b1;
				bstep_q <= '0;
			end else if (blend_busy_q) begin
				case (bstep_q)
					3'd0: abp_q <= quot;
					3'd1: abt_q <= quot;
					3'd2: dcp_q <= quot;
					3'd3: dct_q <= quot;
					3'd4: res_pan <= quot[15:0];
					default: res_tilt <= quot[15:0];
				endcase
				bstep_q <= bstep_q + 3'd1;
				if (bstep_q == 3'd5) begin
					blend_busy_q <= 1'b0;
					blend_done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ hw/rtl/lsgs_ctrl.sv @@
// Controller: scan phases, grid position and output handshake.
// Depends on lsgs_pkg.
module lsgs_ctrl #(
	parameter int unsigned MAX_SAMPLES = lsgs_pkg::DefMaxSamples,
	parameter bit ZIGZAG = lsgs_pkg::DefZigzag,
	parameter int unsigned PW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [7:0]        pan_speed,
	input  logic [7:0]        tilt_speed,
	input  logic              point_valid,
	input  logic [7:0]        laser_power,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              move_valid,
	output logic              laser_valid,
	output logic [7:0]        laser_level,
	output logic              rotate_stop,
	output logic              point_accept,
	output logic [9:0]        cell_u,
	output logic [9:0]        cell_v,
	output logic              busy_res,
	output logic              done_res,
	output logic              tgt_sel,
	input  logic [10:0]       samples_u,
	input  logic [10:0]       samples_v,
	input  logic [15:0]       warmup_ticks,
	output lsgs_pkg::dp_cmd_t cmd,
	input  lsgs_pkg::dp_sts_t sts,
	output logic [PW-1:0]     pos,
	output logic [PW-1:0]     count
);
	import lsgs_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_FU, S_FV, S_BLEND, S_OUT} st_t;
	typedef enum logic [1:0] {PH_MOVING, PH_SCANNING, PH_WAITING} ph_t;

	st_t st_q;
	ph_t phase_q;
	logic active_q;
	logic [PW-1:0] pos_u_q, pos_v_q;
	logic [15:0] since_q;
	logic [7:0] saved_q;

	logic [PW-1:0] nu, nv, nu_adv, nv_adv;

	function automatic logic [PW-1:0] eff(input logic [10:0] n);
		logic [PW-1:0] r;
		if (n == 11'd0) r = PW'(1);
		else if ({{PW{1'b0}}, n} > (PW+11)'(MAX_SAMPLES)) r = PW'(MAX_SAMPLES);
		else r = PW'(n);
		return r;
	endfunction

	assign nu = eff(samples_u);
	assign nv = eff(samples_v);
	assign nu_adv = nu;
	assign nv_adv = nv;

	// hold the input while an item is worked out or a result waits
	assign in_stall = (st_q != S_IDLE) || out_valid;
	assign pos = (st_q == S_FV) ? pos_v_q : pos_u_q;
	assign count = (st_q == S_FV) ? nv : nu;

	// next-position logic for an advance
	logic [PW-1:0] adv_u, adv_v;
	logic adv_fin;
	always_comb begin
		adv_u = pos_u_q;
		adv_v = pos_v_q;
		adv_fin = 1'b0;
		if (ZIGZAG && pos_v_q[0]) begin
			if (pos_u_q == '0) begin
				adv_v = pos_v_q + 1'b1;
				adv_fin = ({1'b0, pos_v_q} + 1'b1) >= {1'b0, nv_adv};
			end else begin
				adv_u = pos_u_q - 1'b1;
			end
		end else if (({1'b0, pos_u_q} + 1'b1) >= {1'b0, nu_adv}) begin
			adv_u = ZIGZAG ? nu_adv - 1'b1 : '0;
			adv_v = pos_v_q + 1'b1;
			adv_fin = ({1'b0, pos_v_q} + 1'b1) >= {1'b0, nv_adv};
		end else begin
			adv_u = pos_u_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			phase_q <= PH_MOVING;
			active_q <= 1'b0;
			pos_u_q <= '0;
			pos_v_q <= '0;
			since_q <= '0;
			saved_q <= '0;
			out_valid <= 1'b0;
			cmd <= '0;
			tgt_sel <= 1'b0;
			move_valid <= 1'b0;
			laser_valid <= 1'b0;
			laser_level <= '0;
			rotate_stop <= 1'b0;
			point_accept <= 1'b0;
			cell_u <= '0;
			cell_v <= '0;
			busy_res <= 1'b0;
			done_res <= 1'b0;
		end else begin
			cmd <= '0;
			case (st_q)
				S_IDLE: begin
					if (in_valid && !out_valid) begin
						move_valid <= 1'b0;
						tgt_sel <= 1'b0;
						laser_valid <= 1'b0;
						laser_level <= '0;
						rotate_stop <= 1'b0;
						point_accept <= 1'b0;
						cell_u <= '0;
						cell_v <= '0;
						done_res <= 1'b0;
						busy_res <= active_q;
						st_q <= S_OUT;
						case (opcode)
							OP_START: begin
								saved_q <= laser_power;
								pos_u_q <= '0;
								pos_v_q <= '0;
								active_q <= 1'b1;
								busy_res <= 1'b1;
								laser_valid <= 1'b1;
								laser_level <= DimLevel;
								phase_q <= PH_MOVING;
								since_q <= '0;
								move_valid <= 1'b1;
								cmd.frac_u_start <= 1'b1;
								st_q <= S_FU;
							end
							OP_STOP: begin
								active_q <= 1'b0;
								busy_res <= 1'b0;
								rotate_stop <= 1'b1;
								laser_valid <= 1'b1;
								laser_level <= saved_q;
							end
							OP_STATUS: begin
								if (active_q && phase_q == PH_MOVING
									&& since_q >= warmup_ticks
									&& pan_speed == 8'd0 && tilt_speed == 8'd0) begin
									phase_q <= PH_SCANNING;
									laser_valid <= 1'b1;
									laser_level <= saved_q;
								end
							end
							OP_TRI: begin
								if (active_q && phase_q == PH_SCANNING && point_valid) begin
									point_accept <= 1'b1;
									cell_u <= 10'(pos_u_q);
									cell_v <= 10'(pos_v_q);
									phase_q <= PH_WAITING;
									laser_valid <= 1'b1;
									laser_level <= DimLevel;
								end else if (active_q && phase_q == PH_WAITING
									&& !point_valid) begin
									pos_u_q <= adv_u;
									pos_v_q <= adv_v;
									if (!adv_fin) begin
										phase_q <= PH_MOVING;
										since_q <= '0;
										move_valid <= 1'b1;
										cmd.frac_u_start <= 1'b1;
										st_q <= S_FU;
									end else begin
										active_q <= 1'b0;
										busy_res <= 1'b0;
										laser_valid <= 1'b1;
										laser_level <= saved_q;
										done_res <= 1'b1;
									end
								end
							end
							OP_TICK: begin
								if (since_q != 16'hFFFF) since_q <= since_q + 16'd1;
							end
							default: begin
							end
						endcase
					end else if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
					end
				end
				S_FU: begin
					if (sts.frac_done) begin
						cmd.frac_v_start <= 1'b1;
						st_q <= S_FV;
					end
				end
				S_FV: begin
					if (sts.frac_done) begin
						cmd.blend_start <= 1'b1;
						st_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					if (sts.blend_done) begin
						tgt_sel <= 1'b1;
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/laser_scan_grid_sequencer.sv @@
// Laser scan grid sequencer: top level, configuration registers and outputs.
// Depends on lsgs_pkg, lsgs_ctrl and lsgs_datapath.
// Flow: an item that issues no move goes straight to S_OUT; an item that issues
// a move passes through S_FU, S_FV and S_BLEND first, for two bit-serial
// fraction divisions and the six-step blend.
// One item at a time: the next input transfer comes at the earliest in the
// cycle after the result transfer.
// Reset: asynchronous, clears scan state and loads register defaults.
module laser_scan_grid_sequencer #(
	parameter int unsigned MAX_SAMPLES = lsgs_pkg::DefMaxSamples,
	parameter bit ZIGZAG = lsgs_pkg::DefZigzag
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic [7:0]         pan_speed,
	input  logic [7:0]         tilt_speed,
	input  logic               point_valid,
	input  logic [7:0]         laser_power,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               move_valid,
	output logic signed [15:0] target_pan,
	output logic signed [15:0] target_tilt,
	output logic               laser_valid,
	output logic [7:0]         laser_level,
	output logic               rotate_stop,
	output logic               point_accept,
	output logic [9:0]         cell_u,
	output logic [9:0]         cell_v,
	output logic               busy_res,
	output logic               done_res
);
	import lsgs_pkg::*;

	localparam int unsigned PW = $clog2(MAX_SAMPLES + 1);

	logic [31:0] corner_a_q, corner_b_q, corner_c_q, corner_d_q;
	logic [10:0] samples_u_q, samples_v_q;
	logic [15:0] warmup_q;

	// register file: take a write on any enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_a_q <= '0;
			corner_b_q <= '0;
			corner_c_q <= '0;
			corner_d_q <= '0;
			samples_u_q <= 11'd2;
			samples_v_q <= 11'd2;
			warmup_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CORNER_A: corner_a_q <= cfg_data;
				CFG_CORNER_B: corner_b_q <= cfg_data;
				CFG_CORNER_C: corner_c_q <= cfg_data;
				CFG_CORNER_D: corner_d_q <= cfg_data;
				CFG_SAMPLES_U: samples_u_q <= cfg_data[10:0];
				CFG_SAMPLES_V: samples_v_q <= cfg_data[10:0];
				CFG_WARMUP: warmup_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [PW-1:0] pos, count;
	logic signed [15:0] res_pan, res_tilt;
	logic tgt_sel;

	lsgs_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .ZIGZAG(ZIGZAG), .PW(PW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .pan_speed, .tilt_speed,
		.point_valid, .laser_power, .out_valid, .out_stall, .move_valid,
		.laser_valid, .laser_level, .rotate_stop, .point_accept, .cell_u,
		.cell_v, .busy_res, .done_res, .tgt_sel,
		.samples_u(samples_u_q), .samples_v(samples_v_q),
		.warmup_ticks(warmup_q), .cmd, .sts, .pos, .count
	);

	lsgs_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .PW(PW)) u_dp (
		.clk, .arst_n, .cmd, .sts, .pos, .count,
		.corner_a(corner_a_q), .corner_b(corner_b_q),
		.corner_c(corner_c_q), .corner_d(corner_d_q),
		.res_pan, .res_tilt
	);

	// targets read zero unless this transfer carries a move
	assign target_pan = tgt_sel ? res_pan : 16'sd0;
	assign target_tilt = tgt_sel ? res_tilt : 16'sd0;

	a_move_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !move_valid |-> target_pan == 16'sd0 && target_tilt == 16'sd0)
		else $error("target without move");
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result waits");
	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while busy");
endmodule
